[sv/grid_local_peak_finder_top_defines.svh]
// Assertion macros shared by the peak finder RTL.
// Both macros sample on i_clk; the first is held off while i_rst_n is low.
`ifndef GRID_LOCAL_PEAK_FINDER_TOP_DEFINES_SVH
`define GRID_LOCAL_PEAK_FINDER_TOP_DEFINES_SVH
`ifndef SYNTH
`define GLPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GLPF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GLPF_ASSERT(lbl, prop, msg)
`define GLPF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/glpf_pkg.sv]
`timescale 1ns / 1ps

package glpf_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_VALUE_WIDTH = 16;

    // Fixed widths of the result fields and configuration registers.
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int NUM_ROWS_W = 13;
    localparam int NUM_COLS_W = 11;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_TDATA_W = 24;

    // Smallest grid dimension, also the reset value of both dimensions.
    localparam int MIN_DIM = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } t_cfg_idx;

    // Input item kinds carried on tuser.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // One decided cell.
    typedef struct packed {
        logic                 last;
        logic                 is_peak;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
    } t_result;

    // Line store access controls for one cycle.
    typedef struct packed {
        logic rd_en;
        logic wr_mid_en;
        logic wr_up_en;
    } t_ls_ctrl;

endpackage

[sv/glpf_ram.sv]
`timescale 1ns / 1ps

module glpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port; registered read returns the old word on a collision.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/glpf_line_store.sv]
`timescale 1ns / 1ps

module glpf_line_store
    import glpf_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_WIDTH,
    parameter int DEPTH = DEF_MAX_COLS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ls_ctrl                 i_ctrl,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_mid_data,
    input  logic [WIDTH-1:0]         i_wr_up_data,
    output logic [WIDTH-1:0]         o_mid_cur,
    output logic [WIDTH-1:0]         o_mid_right,
    output logic [WIDTH-1:0]         o_up_cur
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [ADDR_W-1:0] rd_addr_right;
    logic [WIDTH-1:0]  mid_a_data;
    logic [WIDTH-1:0]  mid_b_data;
    logic [WIDTH-1:0]  up_data;

    logic              r_fwd_a;
    logic              r_fwd_b;
    logic              r_fwd_u;
    logic [WIDTH-1:0]  r_fwd_mid;
    logic [WIDTH-1:0]  r_fwd_up;

    assign rd_addr_right = i_rd_addr + ADDR_W'(1);

    // Middle line is kept twice so that a column and its right neighbor
    // can be read in the same cycle.
    glpf_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_mid_a (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.wr_mid_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_mid_data),
        .i_rd_en   (i_ctrl.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (mid_a_data)
    );

    glpf_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_mid_b (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.wr_mid_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_mid_data),
        .i_rd_en   (i_ctrl.rd_en),
        .i_rd_addr (rd_addr_right),
        .o_rd_data (mid_b_data)
    );

    glpf_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_up (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.wr_up_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_up_data),
        .i_rd_en   (i_ctrl.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (up_data)
    );

    // A read that meets a write to the same entry in the same cycle takes
    // the written word; the flags hold along with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
            r_fwd_u <= 1'b0;
        end else if (i_ctrl.rd_en) begin
            r_fwd_a <= i_ctrl.wr_mid_en && (i_wr_addr == i_rd_addr);
            r_fwd_b <= i_ctrl.wr_mid_en && (i_wr_addr == rd_addr_right);
            r_fwd_u <= i_ctrl.wr_up_en && (i_wr_addr == i_rd_addr);
        end
    end

    // Forwarded words.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_fwd_mid <= i_wr_mid_data;
            r_fwd_up  <= i_wr_up_data;
        end
    end

    assign o_mid_cur   = r_fwd_a ? r_fwd_mid : mid_a_data;
    assign o_mid_right = r_fwd_b ? r_fwd_mid : mid_b_data;
    assign o_up_cur    = r_fwd_u ? r_fwd_up  : up_data;

endmodule

[sv/glpf_out_buf.sv]
`timescale 1ns / 1ps
`include "grid_local_peak_finder_top_defines.svh"

module glpf_out_buf
    import glpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_m_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    pop;

    assign pop     = r_out_valid && i_m_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Output register plus one skid entry; the input side stalls only
    // when both are full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload movement follows the same cases.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    `GLPF_ASSERT(a_skid_implies_out, r_skid_valid |-> r_out_valid, "skid holds data while output is empty")

endmodule

[sv/grid_local_peak_finder_top.sv]
// The deciding transfer pushes a result into the output register, or the skid entry if occupied.
// Throughput: one item per cycle while s_axis_tready is high; each line store is read once per
// advancing item at the next column, prefetched so its registered read data meets the next item.
// Reset (synchronous, i_rst_n low) clears counters, flags, left neighbor and output buffer;
// line store contents are not cleared and are only used after being written.
`timescale 1ns / 1ps
`include "grid_local_peak_finder_top_defines.svh"

module grid_local_peak_finder_top
    import glpf_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                i_cfg_data,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // value, zero pad
    input  logic                                 s_axis_tuser,  // action
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [OUT_TDATA_W-1:0]               m_axis_tdata,  // row, col, zero pad
    output logic                                 m_axis_tuser,  // is_peak
    output logic                                 m_axis_tlast   // last
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);

    // Clamped grid dimensions.
    logic [ROW_W-1:0]  r_rows;
    logic [COLS_W-1:0] r_cols;
    logic [31:0]       cfg_rows_wide;
    logic [31:0]       cfg_cols_wide;

    // Scan state.
    logic [ADDR_W-1:0]             r_col;
    logic [ROW_W-1:0]              r_row;
    logic                          r_flushing;
    logic signed [VALUE_WIDTH-1:0] r_left;
    logic [ADDR_W-1:0]             n_col;
    logic [ROW_W-1:0]              n_row;
    logic                          n_flushing;
    logic signed [VALUE_WIDTH-1:0] n_left;

    logic                          in_xfer;
    logic                          is_pix;
    logic                          pixel_adv;
    logic                          flush_adv;
    logic                          col_end;
    logic [ADDR_W-1:0]             col_inc;
    logic [ROW_W-1:0]              row_inc;

    logic signed [VALUE_WIDTH-1:0] pix_value;
    logic signed [VALUE_WIDTH-1:0] cur_val;
    logic signed [VALUE_WIDTH-1:0] up;
    logic signed [VALUE_WIDTH-1:0] right;
    logic signed [VALUE_WIDTH-1:0] below_ref;
    logic [VALUE_WIDTH-1:0]        mid_cur;
    logic [VALUE_WIDTH-1:0]        mid_right;
    logic [VALUE_WIDTH-1:0]        up_cur;

    t_ls_ctrl ls_ctrl;
    t_result  res;
    t_result  out_data;
    logic     res_valid;
    logic     ob_ready;

    // Configuration writes store the dimensions already clamped.
    assign cfg_rows_wide = 32'(i_cfg_data);
    assign cfg_cols_wide = 32'(i_cfg_data[NUM_COLS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROW_W'(MIN_DIM);
            r_cols <= COLS_W'(MIN_DIM);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_ROWS: begin
                    if (cfg_rows_wide < 32'(MIN_DIM)) begin
                        r_rows <= ROW_W'(MIN_DIM);
                    end else if (cfg_rows_wide > 32'(MAX_ROWS)) begin
                        r_rows <= ROW_W'(MAX_ROWS);
                    end else begin
                        r_rows <= ROW_W'(cfg_rows_wide);
                    end
                end
                CFG_NUM_COLS: begin
                    if (cfg_cols_wide < 32'(MIN_DIM)) begin
                        r_cols <= COLS_W'(MIN_DIM);
                    end else if (cfg_cols_wide > 32'(MAX_COLS)) begin
                        r_cols <= COLS_W'(MAX_COLS);
                    end else begin
                        r_cols <= COLS_W'(cfg_cols_wide);
                    end
                end
                default: begin
                    r_rows <= r_rows;
                end
            endcase
        end
    end

    // Item classification; ignored items are taken without any effect.
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign is_pix    = (s_axis_tuser == ACT_PIXEL);
    assign pixel_adv = in_xfer && is_pix && !r_flushing;
    assign flush_adv = in_xfer && (s_axis_tuser == ACT_FLUSH) && r_flushing;
    assign pix_value = s_axis_tdata[VALUE_WIDTH-1:0];

    assign col_end = (COLS_W'(r_col) + COLS_W'(1)) >= r_cols;
    assign col_inc = r_col + ADDR_W'(1);
    assign row_inc = r_row + ROW_W'(1);

    // Neighborhood of the cell in the current column.
    assign cur_val   = mid_cur;
    assign up        = up_cur;
    assign right     = mid_right;
    assign below_ref = is_pix ? pix_value : up;

    // Peak decision and result fields.
    always_comb begin
        res.is_peak = (cur_val >= below_ref)
                      && (!is_pix || (r_row <= ROW_W'(1)) || (cur_val >= up))
                      && ((r_col == '0) || (cur_val >= r_left))
                      && (col_end || (cur_val >= right));
        res.row     = ROW_OUT_W'(r_row - ROW_W'(1));
        res.col     = COL_OUT_W'(r_col);
        res.last    = flush_adv && col_end;
    end

    assign res_valid = (pixel_adv && (r_row != '0)) || flush_adv;

    // Next scan state.
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_flushing = r_flushing;
        n_left     = r_left;
        if (pixel_adv) begin
            if (r_row != '0) begin
                n_left = cur_val;
            end
            if (col_end) begin
                n_col = '0;
                n_row = row_inc;
                if (row_inc >= r_rows) begin
                    n_flushing = 1'b1;
                end
            end else begin
                n_col = col_inc;
            end
        end else if (flush_adv) begin
            if (col_end) begin
                n_flushing = 1'b0;
                n_col      = '0;
                n_row      = '0;
                n_left     = '0;
            end else begin
                n_left = cur_val;
                n_col  = col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_flushing <= 1'b0;
            r_left     <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_flushing <= n_flushing;
            r_left     <= n_left;
        end
    end

    // Line store accesses: write the current column, prefetch the next one.
    always_comb begin
        ls_ctrl.rd_en     = pixel_adv || flush_adv;
        ls_ctrl.wr_mid_en = pixel_adv;
        ls_ctrl.wr_up_en  = pixel_adv && (r_row != '0);
    end

    glpf_line_store #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_COLS)) u_line_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ls_ctrl),
        .i_rd_addr     (n_col),
        .i_wr_addr     (r_col),
        .i_wr_mid_data (pix_value),
        .i_wr_up_data  (cur_val),
        .o_mid_cur     (mid_cur),
        .o_mid_right   (mid_right),
        .o_up_cur      (up_cur)
    );

    glpf_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res_valid),
        .i_data    (res),
        .o_ready   (ob_ready),
        .o_valid   (m_axis_tvalid),
        .o_data    (out_data),
        .i_m_ready (m_axis_tready)
    );

    assign s_axis_tready = ob_ready;
    assign m_axis_tdata  = {{(OUT_TDATA_W - COL_OUT_W - ROW_OUT_W){1'b0}},
                            out_data.col, out_data.row};
    assign m_axis_tuser  = out_data.is_peak;
    assign m_axis_tlast  = out_data.last;

    `GLPF_ASSERT(a_flush_has_rows, r_flushing |-> (r_row != '0), "flushing with no stored row")
    `GLPF_ASSERT(a_flush_end_clears, (flush_adv && col_end) |=> (!r_flushing && (r_row == '0) && (r_col == '0)), "scan state not cleared after last cell")
    `GLPF_ASSERT(a_last_only_in_flush, (res_valid && res.last) |-> flush_adv, "final mark outside the flush phase")

endmodule
